// File: rtl/b32m_pkg.sv
// shared constants, types and functions for the bech32m address encoder
`timescale 1ns / 1ps
package b32m_pkg;

  localparam int unsigned MAX_HRP_LEN = 128;
  localparam int unsigned HRP_CNT_W = $clog2(MAX_HRP_LEN + 1);
  localparam int unsigned HRP_IDX_W = (MAX_HRP_LEN > 1) ? $clog2(MAX_HRP_LEN) : 1;

  localparam int unsigned POLY_W = 30;

  // item opcodes
  localparam logic [1:0] OP_HRP  = 2'd0;
  localparam logic [1:0] OP_VER  = 2'd1;
  localparam logic [1:0] OP_BYTE = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [7:0] SEP_CHAR = 8'h31;
  localparam logic [POLY_W-1:0] POLY_INIT = 30'd1;
  localparam logic [POLY_W-1:0] FINAL_XOR = 30'h2bc830a3;

  localparam logic [POLY_W-1:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  // command from the sequencer to the checksum unit
  typedef struct packed {
    logic       init;
    logic       fold;
    logic [4:0] sym;
    logic       fin;
    logic       shift;
  } poly_cmd_t;

  function automatic logic [POLY_W-1:0] poly_fold(input logic [POLY_W-1:0] p,
                                                  input logic [4:0] sym);
    logic [4:0]        top;
    logic [POLY_W-1:0] r;
    top = p[29:25];
    r = {p[24:0], sym};
    for (int i = 0; i < 5; i++) begin
      if (top[i]) begin
        r = r ^ GEN[i];
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] sym_char(input logic [4:0] sym);
    logic [4:0] idx;
    idx = 5'd31 - sym;
    return CHARSET[{idx, 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/b32m_hrp_mem.sv
// buffer for hrp characters, one write and one registered read port
`timescale 1ns / 1ps
module b32m_hrp_mem (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [b32m_pkg::HRP_IDX_W-1:0] wr_addr_i,
  input  logic [7:0]                     wr_data_i,
  input  logic                           rd_en_i,
  input  logic [b32m_pkg::HRP_IDX_W-1:0] rd_addr_i,
  output logic [7:0]                     rd_data_o
);

  logic [7:0] mem [b32m_pkg::MAX_HRP_LEN];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/b32m_polymod.sv
// 30-bit checksum register with one fold step per cycle
`timescale 1ns / 1ps
module b32m_polymod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  b32m_pkg::poly_cmd_t         cmd_i,
  output logic [b32m_pkg::POLY_W-1:0] poly_o
);

  logic [b32m_pkg::POLY_W-1:0] poly_d, poly_q;
  logic [b32m_pkg::POLY_W-1:0] folded;

  always_comb begin
    folded = b32m_pkg::poly_fold(poly_q, cmd_i.sym);
    poly_d = poly_q;
    if (cmd_i.init) begin
      poly_d = b32m_pkg::POLY_INIT;
    end else if (cmd_i.fold) begin
      poly_d = cmd_i.fin ? (folded ^ b32m_pkg::FINAL_XOR) : folded;
    end else if (cmd_i.shift) begin
      // expose the next checksum symbol in the top five bits
      poly_d = {poly_q[24:0], 5'b00000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= b32m_pkg::POLY_INIT;
    end else begin
      poly_q <= poly_d;
    end
  end

  assign poly_o = poly_q;

endmodule

// File: rtl/bech32m_address_encoder.sv
// top level of the streaming bech32m address encoder
`timescale 1ns / 1ps
// usage
//   input channel (in_valid_i / in_ready_o) takes one request per item:
//   opcode 0 = hrp character, 1 = witness version, 2 = payload byte, 3 ignored.
//   end_of_address_i on a version or payload request closes the address.
//   output channel (out_valid_o / out_ready_i) returns the address characters
//   one at a time; final_char_o marks the last checksum character.
// steps per item
//   hrp character: echoed to the output, stored and folded
//   payload byte: one step per symbol plus one to trim leftover bits
//   witness version: separator, N buffered hrp characters, version; the buffer
//     is read back one entry per cycle through the registered memory port
//   last item adds a pad step, six fold steps and six checksum
//     characters; the checksum unit does one fold per cycle
// the block takes one item at a time; in_ready_o is high only while idle.
// a held output character waits in the output register while the next
// item is already taken. when the receiver stalls, the sequencer waits on
// each new character. reset clears the checksum to one and empties the hrp
// buffer count and the bit accumulator; the same happens after each address.
module bech32m_address_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] value_i,
  input  logic       end_of_address_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       final_char_o
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HRP   = 4'd1;
  localparam logic [3:0] S_VSEP  = 4'd2;
  localparam logic [3:0] S_VWALK = 4'd3;
  localparam logic [3:0] S_VSYM  = 4'd4;
  localparam logic [3:0] S_BYTE  = 4'd5;
  localparam logic [3:0] S_PAD   = 4'd6;
  localparam logic [3:0] S_ZERO  = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;

  localparam int unsigned CW = b32m_pkg::HRP_CNT_W;
  localparam int unsigned IW = b32m_pkg::HRP_IDX_W;

  logic [3:0]    state_d, state_q;
  logic [7:0]    val_d, val_q;
  logic          last_d, last_q;
  logic [CW-1:0] hrp_cnt_d, hrp_cnt_q;
  logic [CW-1:0] walk_d, walk_q;
  logic [11:0]   acc_d, acc_q;
  logic [3:0]    bc_d, bc_q;
  logic [2:0]    k_d, k_q;

  // output register
  logic       ovalid_d, ovalid_q;
  logic [7:0] ochar_q;
  logic       ofinal_q;
  logic       emit_ok;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_final;

  // memory and checksum hookup
  logic                        wr_en;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic [7:0]                  rd_data;
  b32m_pkg::poly_cmd_t         pcmd;
  logic [b32m_pkg::POLY_W-1:0] poly;

  logic          in_acc;
  logic [3:0]    bc_sub;
  logic [11:0]   sh_down;
  logic [11:0]   sh_up;
  logic [3:0]    pad_amt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign emit_ok    = !ovalid_q || out_ready_i;

  assign bc_sub  = bc_q - 4'd5;
  assign sh_down = acc_q >> bc_sub;
  assign pad_amt = 4'd5 - bc_q;
  assign sh_up   = acc_q << pad_amt;

  always_comb begin
    state_d    = state_q;
    val_d      = val_q;
    last_d     = last_q;
    hrp_cnt_d  = hrp_cnt_q;
    walk_d     = walk_q;
    acc_d      = acc_q;
    bc_d       = bc_q;
    k_d        = k_q;
    emit       = 1'b0;
    emit_char  = val_q;
    emit_final = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    pcmd       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d  = value_i;
          last_d = end_of_address_i;
          case (opcode_i)
            b32m_pkg::OP_HRP: begin
              // characters past the buffer capacity are dropped silently
              if (hrp_cnt_q < CW'(b32m_pkg::MAX_HRP_LEN)) begin
                state_d = S_HRP;
              end
            end
            b32m_pkg::OP_VER: begin
              state_d = S_VSEP;
            end
            b32m_pkg::OP_BYTE: begin
              acc_d   = {acc_q[3:0], value_i};
              bc_d    = bc_q + 4'd8;
              state_d = S_BYTE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_HRP: begin
        if (emit_ok) begin
          // echo, store and fold the high three bits
          emit      = 1'b1;
          emit_char = val_q;
          wr_en     = 1'b1;
          hrp_cnt_d = hrp_cnt_q + CW'(1);
          pcmd.fold = 1'b1;
          pcmd.sym  = {2'b00, val_q[7:5]};
          state_d   = S_IDLE;
        end
      end

      S_VSEP: begin
        if (emit_ok) begin
          // separator, then the zero between the two hrp expansions
          emit      = 1'b1;
          emit_char = b32m_pkg::SEP_CHAR;
          pcmd.fold = 1'b1;
          pcmd.sym  = 5'd0;
          if (hrp_cnt_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            walk_d  = CW'(1);
            state_d = S_VWALK;
          end else begin
            state_d = S_VSYM;
          end
        end
      end

      S_VWALK: begin
        // fold the entry read last cycle, fetch the next one
        pcmd.fold = 1'b1;
        pcmd.sym  = rd_data[4:0];
        if (walk_q == hrp_cnt_q) begin
          hrp_cnt_d = '0;
          state_d   = S_VSYM;
        end else begin
          rd_en   = 1'b1;
          rd_addr = walk_q[IW-1:0];
          walk_d  = walk_q + CW'(1);
        end
      end

      S_VSYM: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = b32m_pkg::sym_char(val_q[4:0]);
          pcmd.fold = 1'b1;
          pcmd.sym  = val_q[4:0];
          state_d   = last_q ? S_PAD : S_IDLE;
        end
      end

      S_BYTE: begin
        if (bc_q >= 4'd5) begin
          if (emit_ok) begin
            emit      = 1'b1;
            emit_char = b32m_pkg::sym_char(sh_down[4:0]);
            pcmd.fold = 1'b1;
            pcmd.sym  = sh_down[4:0];
            bc_d      = bc_sub;
          end
        end else begin
          // keep only the leftover bits
          acc_d   = acc_q & ((12'd1 << bc_q) - 12'd1);
          state_d = last_q ? S_PAD : S_IDLE;
        end
      end

      S_PAD: begin
        if (bc_q == 4'd0) begin
          k_d     = '0;
          state_d = S_ZERO;
        end else if (emit_ok) begin
          emit      = 1'b1;
          emit_char = b32m_pkg::sym_char(sh_up[4:0]);
          pcmd.fold = 1'b1;
          pcmd.sym  = sh_up[4:0];
          k_d       = '0;
          state_d   = S_ZERO;
        end
      end

      S_ZERO: begin
        pcmd.fold = 1'b1;
        pcmd.sym  = 5'd0;
        if (k_q == 3'd5) begin
          pcmd.fin = 1'b1;
          k_d      = '0;
          state_d  = S_CHK;
        end else begin
          k_d = k_q + 3'd1;
        end
      end

      S_CHK: begin
        if (emit_ok) begin
          emit       = 1'b1;
          emit_char  = b32m_pkg::sym_char(poly[29:25]);
          emit_final = (k_q == 3'd5);
          if (k_q == 3'd5) begin
            // address done, start over
            pcmd.init = 1'b1;
            hrp_cnt_d = '0;
            acc_d     = '0;
            bc_d      = '0;
            k_d       = '0;
            state_d   = S_IDLE;
          end else begin
            pcmd.shift = 1'b1;
            k_d        = k_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hrp_cnt_q <= '0;
      walk_q    <= '0;
      acc_q     <= '0;
      bc_q      <= '0;
      k_q       <= '0;
      last_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      hrp_cnt_q <= hrp_cnt_d;
      walk_q    <= walk_d;
      acc_q     <= acc_d;
      bc_q      <= bc_d;
      k_q       <= k_d;
      last_q    <= last_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (emit) begin
      ochar_q  <= emit_char;
      ofinal_q <= emit_final;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_char_o   = ochar_q;
  assign final_char_o = ofinal_q;

  b32m_hrp_mem u_hrp_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (hrp_cnt_q[IW-1:0]),
    .wr_data_i (val_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  b32m_polymod u_polymod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pcmd),
    .poly_o (poly)
  );

endmodule

// File: rtl/b32m_checker.sv
// port-level checks for the bech32m address encoder, bound to the top level
`timescale 1ns / 1ps
module b32m_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] opcode_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       final_char_o
);

  // a stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(final_char_o))
    else $error("output character changed while stalled");

  // an unused opcode leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == b32m_pkg::OP_NONE |=> in_ready_o)
    else $error("ignored request made the block busy");

  // a version request always keeps the block busy for the separator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == b32m_pkg::OP_VER |=> !in_ready_o)
    else $error("version request did not start work");

  // a payload byte always keeps the block busy for at least one symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == b32m_pkg::OP_BYTE |=> !in_ready_o)
    else $error("payload request did not start work");

endmodule

bind bech32m_address_encoder b32m_checker u_b32m_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .opcode_i     (opcode_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_char_o   (out_char_o),
  .final_char_o (final_char_o)
);

// File: tb/bech32m_address_checker.sv
// predicts and checks the characters the bech32m address encoder returns
`timescale 1ns / 1ps
module bech32m_address_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] value_i,
  input  logic       end_of_address_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_char_i,
  input  logic       final_char_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         chars_seen_o
);

  localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [149:0] GEN_TAPS = {30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa,
                                       30'h26508e6d, 30'h3b6a57b2};
  localparam logic [29:0]  M_CONST = 30'h2bc830a3;
  localparam logic [7:0]   SEPARATOR = "1";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } addr_char_t;

  addr_char_t  expected_chars [$];
  addr_char_t  oldest;
  int          fails = 0;
  int          chars_seen = 0;

  // running copy of the encoder state
  logic [29:0] poly_acc;
  logic [7:0]  hrp_buf [b32m_pkg::MAX_HRP_LEN];
  int unsigned hrp_len;
  logic [11:0] bit_pool;
  int unsigned pool_bits;

  function automatic logic [29:0] bch_step(input logic [29:0] acc, input logic [4:0] sym);
    logic [4:0]  hi;
    logic [29:0] nxt;
    hi = acc[29:25];
    nxt = {acc[24:0], sym};
    for (int k = 0; k < 5; k++) begin
      if (hi[k]) begin
        nxt = nxt ^ GEN_TAPS[30*k +: 30];
      end
    end
    return nxt;
  endfunction

  function automatic logic [7:0] charset_of(input logic [4:0] sym);
    return ALPHABET[8 * (31 - int'(sym)) +: 8];
  endfunction

  task automatic clear_state();
    poly_acc = 30'd1;
    hrp_len = 0;
    bit_pool = '0;
    pool_bits = 0;
  endtask

  task automatic queue_char(input logic [7:0] ch, input logic last);
    addr_char_t e;
    e.ch = ch;
    e.last = last;
    expected_chars = {expected_chars, e};
  endtask

  task automatic emit_symbol(input logic [4:0] sym);
    poly_acc = bch_step(poly_acc, sym);
    queue_char(charset_of(sym), 1'b0);
  endtask

  task automatic close_address();
    logic [29:0] chk;
    // leftover bits are zero-padded to one more symbol
    if (pool_bits > 0) begin
      emit_symbol(5'(bit_pool << (5 - pool_bits)));
    end
    repeat (6) poly_acc = bch_step(poly_acc, 5'd0);
    chk = poly_acc ^ M_CONST;
    for (int k = 0; k < 6; k++) begin
      queue_char(charset_of(chk[25 - 5*k +: 5]), k == 5);
    end
    clear_state();
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [7:0] val,
                              input logic eoa);
    case (op)
      b32m_pkg::OP_HRP: begin
        // full buffer drops the character entirely
        if (hrp_len < b32m_pkg::MAX_HRP_LEN) begin
          hrp_buf[hrp_len] = val;
          hrp_len++;
          poly_acc = bch_step(poly_acc, {2'b00, val[7:5]});
          queue_char(val, 1'b0);
        end
      end
      b32m_pkg::OP_VER: begin
        queue_char(SEPARATOR, 1'b0);
        poly_acc = bch_step(poly_acc, 5'd0);
        for (int k = 0; k < hrp_len; k++) begin
          poly_acc = bch_step(poly_acc, hrp_buf[k][4:0]);
        end
        hrp_len = 0;
        emit_symbol(val[4:0]);
        if (eoa) begin
          close_address();
        end
      end
      b32m_pkg::OP_BYTE: begin
        bit_pool = {bit_pool[3:0], val};
        pool_bits += 8;
        while (pool_bits >= 5) begin
          pool_bits -= 5;
          emit_symbol(5'(bit_pool >> pool_bits));
        end
        bit_pool &= (12'd1 << pool_bits) - 12'd1;
        if (eoa) begin
          close_address();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_chars.delete();
      pending_o <= 0;
    end else begin
      // results first: a character accepted now belongs to an older request
      if (out_valid_i && out_ready_i) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character, expected none, got char %h final %b",
                   $time, out_char_i, final_char_i);
          fails++;
        end else begin
          oldest = expected_chars.pop_front();
          if (oldest.ch !== out_char_i) begin
            $display("%0t: out_char mismatch, expected %h, got %h",
                     $time, oldest.ch, out_char_i);
            fails++;
          end
          if (oldest.last !== final_char_i) begin
            $display("%0t: final_char mismatch, expected %b, got %b",
                     $time, oldest.last, final_char_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_item(opcode_i, value_i, end_of_address_i);
      end
      pending_o <= expected_chars.size();
    end
    fail_count_o <= fails;
    chars_seen_o <= chars_seen;
  end

endmodule

// File: tb/tb_bech32m_address_encoder.sv
// testbench top for the bech32m address encoder: stimulus, pacing and verdict
`timescale 1ns / 1ps
module tb_bech32m_address_encoder;

  localparam int ITEM_TARGET = 360;
  // idle limit: longest legal quiet stretch is the long output hold below,
  // or a version request walking a full hrp buffer, plus both sides' gaps
  localparam int IDLE_LIMIT = 2000;
  // after the last expected character: a version walking a full hrp buffer
  // and closing the address keeps the block busy, and this leaves room
  // to catch stray characters
  localparam int DRAIN_CYCLES = 200;
  // receiver holds off this long once, after this many characters
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 250;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] opcode;
  logic [7:0] value;
  logic       eoa;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       final_char;

  int fail_count;
  int pending;
  int chars_seen;
  int sent_items = 0;
  int addresses = 0;
  int idle_cycles = 0;
  bit overflow_done = 1'b0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bech32m_address_encoder u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .value_i         (value),
    .end_of_address_i(eoa),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_char_o      (out_char),
    .final_char_o    (final_char)
  );

  bech32m_address_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .value_i         (value),
    .end_of_address_i(eoa),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_char_i      (out_char),
    .final_char_i    (final_char),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .chars_seen_o    (chars_seen)
  );

  // watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // offer one request; changes land on the falling edge, acceptance is seen
  // at the rising edge. the first 25 of every 100 requests go back to back
  task automatic offer_request(input logic [1:0] op, input logic [7:0] val,
                               input logic last);
    int unsigned gap;
    gap = (sent_items % 100 < 25) ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    eoa      <= last;
    do @(posedge clk); while (!in_ready);
    // ignored opcodes do not count as real requests
    if (op != b32m_pkg::OP_NONE) begin
      sent_items++;
    end
    if (last && (op == b32m_pkg::OP_VER || op == b32m_pkg::OP_BYTE)) begin
      addresses++;
    end
  endtask

  // mostly lower-case letters, now and then any byte
  function automatic logic [7:0] hrp_char();
    if ($urandom_range(0, 3) != 0) begin
      return 8'h61 + 8'($urandom_range(0, 25));
    end
    return 8'($urandom);
  endfunction

  // one well-formed address: hrp characters, version, payload bytes;
  // with no payload the version carries the end flag
  task automatic send_address(input int hrp_n, input int pay_n);
    logic [7:0] ver;
    for (int k = 0; k < hrp_n; k++) begin
      // end flag on an hrp character should be ignored
      offer_request(b32m_pkg::OP_HRP, hrp_char(), 1'($urandom_range(0, 7) == 0));
    end
    ver = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
    offer_request(b32m_pkg::OP_VER, ver, pay_n == 0);
    for (int k = 0; k < pay_n; k++) begin
      offer_request(b32m_pkg::OP_BYTE, 8'($urandom), k == pay_n - 1);
    end
  endtask

  // output side: random hold-off per character, calm stretches, and one
  // long hold so the block fills up and drops in_ready
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else if (taken % 120 < 30) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int hrp_n;
    int pay_n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    opcode = b32m_pkg::OP_HRP;
    value = 8'h00;
    eoa = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, end flag on hrp, all-ones payload byte
    offer_request(b32m_pkg::OP_HRP, 8'h61, 1'b0);
    offer_request(b32m_pkg::OP_HRP, 8'h00, 1'b1);
    offer_request(b32m_pkg::OP_HRP, 8'hff, 1'b0);
    offer_request(b32m_pkg::OP_VER, 8'h00, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'h00, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'hff, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'ha5, 1'b1);
    // unused opcode with everything set: nothing should come out
    offer_request(b32m_pkg::OP_NONE, 8'hff, 1'b1);
    // version-only address, empty hrp, version above 31
    offer_request(b32m_pkg::OP_VER, 8'hff, 1'b1);
    // repeated version, hrp after version, five bytes with no padding
    offer_request(b32m_pkg::OP_HRP, 8'h74, 1'b0);
    offer_request(b32m_pkg::OP_VER, 8'd16, 1'b0);
    offer_request(b32m_pkg::OP_VER, 8'he3, 1'b0);
    offer_request(b32m_pkg::OP_HRP, 8'h71, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'h01, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'h80, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'h7f, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'hfe, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'h55, 1'b1);
    // single byte leaves three bits to pad
    offer_request(b32m_pkg::OP_HRP, 8'h7a, 1'b0);
    offer_request(b32m_pkg::OP_VER, 8'd31, 1'b0);
    offer_request(b32m_pkg::OP_BYTE, 8'hc3, 1'b1);

    // random: mostly whole addresses, some noise, one hrp overflow
    while (sent_items < ITEM_TARGET) begin
      if (addresses >= 6 && !overflow_done) begin
        send_address(b32m_pkg::MAX_HRP_LEN + 3, 4);
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          offer_request(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
        end
      end else begin
        hrp_n = $urandom_range(0, 8);
        pay_n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        send_address(hrp_n, pay_n);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d closed addresses, %0d characters checked",
             sent_items, addresses, chars_seen);
    $display("run: hrp overflow, repeated version, ignored opcode, %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
